// ===== hw/rtl/rtcbcd_pkg.sv =====
// ----------------------------------------------------------------------------
// rtcbcd_pkg: shared types and constants for the three-wire RTC master
// Beat payloads, sequencer phase codes and the BCD helpers.
// ----------------------------------------------------------------------------
package rtcbcd_pkg;

   localparam int BYTE_BITS = 8;
   localparam int BIT_IDX_W = $clog2(2 * BYTE_BITS);
   localparam int PHASE_W   = 6;

   // Sequencer phases
   localparam logic [PHASE_W-1:0] PH_IDLE    = PHASE_W'(0);
   localparam logic [PHASE_W-1:0] PH_CE_HIGH = PHASE_W'(1);
   localparam logic [PHASE_W-1:0] PH_BITS    = PHASE_W'(2);
   localparam logic [PHASE_W-1:0] PH_SDA_LOW = PHASE_W'(2 + 6 * BYTE_BITS);
   localparam logic [PHASE_W-1:0] PH_END     = PHASE_W'(3 + 6 * BYTE_BITS);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // Three ticks per bit
   typedef enum logic [1:0] {
      SLOT_DATA      = 2'd0,
      SLOT_CLK_HIGH  = 2'd1,
      SLOT_CLK_LOW   = 2'd2
   } slot_type;

   typedef struct packed {
      logic       start_req;
      logic       op;
      logic [7:0] reg_addr;
      logic [6:0] value;
      logic       sda_in;
   } req_payload_type;

   typedef struct packed {
      logic       ce;
      logic       sclk;
      logic       sda_out;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_value;
   } rsp_payload_type;

   // Binary 0..127 to packed BCD (tens nibble above 9 for 100..127); tens by reciprocal (x*205)>>11, exact here
   function automatic logic [7:0] bin_to_bcd(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = 15'(v) * 15'd205;
      tens = prod[14:11];
      ones = v - 7'(tens) * 7'd10;
      return {tens, ones[3:0]};
   endfunction

   // Packed BCD to binary, invalid nibbles taken at face value
   function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
      logic [7:0] hi;
      hi = {4'd0, b[7:4]};
      return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
   endfunction

endpackage

// ===== hw/rtl/rtcbcd_seq.sv =====
// ----------------------------------------------------------------------------
// rtcbcd_seq: bus tick sequencer
// Holds the transfer state and works out one tick of bus activity per beat.
// ----------------------------------------------------------------------------
module rtcbcd_seq
   import rtcbcd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  req_payload_type tick,
   output rsp_payload_type result
);

   logic [PHASE_W-1:0]   phase_ff,   phase_in;
   logic [15:0]          tx_ff,      tx_in;
   logic [7:0]           rx_ff,      rx_in;
   logic                 is_read_ff, is_read_in;
   logic [7:0]           last_ff,    last_in;
   logic                 ce_ff,      ce_in;
   logic                 sclk_ff,    sclk_in;
   logic                 sda_ff,     sda_in;
   logic                 drv_ff,     drv_in;
   slot_type             slot_ff,    slot_in;
   logic [BIT_IDX_W-1:0] bit_ff,     bit_in;
   logic                 done;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         tx_ff      <= '0;
         rx_ff      <= '0;
         is_read_ff <= 1'b0;
         last_ff    <= '0;
         ce_ff      <= 1'b0;
         sclk_ff    <= 1'b0;
         sda_ff     <= 1'b0;
         drv_ff     <= 1'b1;
         slot_ff    <= SLOT_DATA;
         bit_ff     <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         tx_ff      <= tx_in;
         rx_ff      <= rx_in;
         is_read_ff <= is_read_in;
         last_ff    <= last_in;
         ce_ff      <= ce_in;
         sclk_ff    <= sclk_in;
         sda_ff     <= sda_in;
         drv_ff     <= drv_in;
         slot_ff    <= slot_in;
         bit_ff     <= bit_in;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      tx_in      = tx_ff;
      rx_in      = rx_ff;
      is_read_in = is_read_ff;
      last_in    = last_ff;
      ce_in      = ce_ff;
      sclk_in    = sclk_ff;
      sda_in     = sda_ff;
      drv_in     = drv_ff;
      slot_in    = slot_ff;
      bit_in     = bit_ff;
      done       = 1'b0;

      if (phase_ff == PH_IDLE) begin
         if (tick.start_req) begin
            is_read_in = tick.op;
            if (tick.op == OP_READ) begin
               tx_in = {8'd0, tick.reg_addr | 8'h01};
            end else begin
               tx_in = {bin_to_bcd(tick.value), tick.reg_addr & 8'hFE};
            end
            rx_in    = '0;
            ce_in    = 1'b0;
            sclk_in  = 1'b0;
            phase_in = PH_CE_HIGH;
         end
      end else if (phase_ff == PH_CE_HIGH) begin
         ce_in    = 1'b1;
         slot_in  = SLOT_DATA;
         bit_in   = '0;
         phase_in = PH_BITS;
      end else if (phase_ff < PH_SDA_LOW) begin
         unique case (slot_ff)
            SLOT_DATA: begin
               // second byte of a read is sampled, not driven
               if (is_read_ff && (bit_ff >= BIT_IDX_W'(BYTE_BITS))) begin
                  drv_in = 1'b0;
                  rx_in  = {tick.sda_in, rx_ff[7:1]};
               end else begin
                  drv_in = 1'b1;
                  sda_in = tx_ff[0];
                  tx_in  = {1'b0, tx_ff[15:1]};
               end
               slot_in = SLOT_CLK_HIGH;
            end
            SLOT_CLK_HIGH: begin
               sclk_in = 1'b1;
               slot_in = SLOT_CLK_LOW;
            end
            SLOT_CLK_LOW: begin
               sclk_in = 1'b0;
               slot_in = SLOT_DATA;
               bit_in  = bit_ff + 1'b1;
            end
            default: begin
               slot_in = SLOT_DATA;
            end
         endcase
         phase_in = phase_ff + 1'b1;
      end else if (phase_ff == PH_SDA_LOW) begin
         drv_in   = 1'b1;
         sda_in   = 1'b0;
         phase_in = PH_END;
      end else if (phase_ff == PH_END) begin
         ce_in = 1'b0;
         done  = 1'b1;
         if (is_read_ff) begin
            last_in = bcd_to_bin(rx_ff);
         end
         phase_in = PH_IDLE;
      end else begin
         phase_in = PH_IDLE;
      end
   end

   always_comb begin
      result.ce         = ce_in;
      result.sclk       = sclk_in;
      result.sda_out    = drv_in & sda_in;
      result.sda_drive  = drv_in;
      result.busy_res   = (phase_in != PH_IDLE);
      result.done_res   = done;
      result.read_value = last_in;
   end

endmodule

// ===== hw/rtl/rtc_three_wire_bcd_master.sv =====
// ----------------------------------------------------------------------------
// rtc_three_wire_bcd_master: three-wire serial RTC register master
// The result beat is registered and appears in the cycle after its tick beat is accepted.
// Accepts one tick per cycle, except while the held result is stalled.
// A full transfer spans 52 ticks (start, CE high, 48 bit ticks, SDA low, end).
// Reset (synchronous, active high) idles the sequencer and empties the
// result register; lines reset with CE, SCLK and SDA low, SDA driven.
// ----------------------------------------------------------------------------
module rtc_three_wire_bcd_master
   import rtcbcd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   logic            accept;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type result;

   // new beat may enter while the held result is being taken
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   rtcbcd_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .tick    (req_data),
      .result  (result)
   );

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== tb/tb_rtc_three_wire_bcd_master.sv =====
// ----------------------------------------------------------------------------
// tb_rtc_three_wire_bcd_master: testbench for the three-wire RTC master
// Feeds bus-tick beats (whole write and read transfers, noise, idle ticks)
// under random gaps and result stalls. Each beat's line levels are predicted
// tick by tick and compared field by field with the result beats, in order.
// ----------------------------------------------------------------------------
module tb_rtc_three_wire_bcd_master;
   import rtcbcd_pkg::*;

   localparam int XFER_TICKS = int'(PH_END) + 1;
   localparam int TOTAL_TICKS = 550;
   localparam int MAX_REPORTS = 40;

   typedef struct {
      req_payload_type beat;
      bit              hold;    // wait for all line levels to drain first
   } tick_item_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   tick_item_type   pending_ticks[$];
   rsp_payload_type expected_lines[$];
   int              n_faults = 0;
   int              n_checked = 0;
   int              req_gap = 0;
   int              req_calm = 0;
   int              rsp_hold = 0;
   int              rsp_calm = 0;

   // predicted master state
   logic [PHASE_W-1:0] seq_phase;
   logic [15:0]        tx_bits;
   logic [7:0]         rx_bits;
   logic               xfer_read;
   logic [7:0]         last_decoded;
   logic               ce_line, sclk_line, sda_line, drive_line;

   rtc_three_wire_bcd_master dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   task automatic clear_bus_state();
      seq_phase    = PH_IDLE;
      tx_bits      = '0;
      rx_bits      = '0;
      xfer_read    = 1'b0;
      last_decoded = '0;
      ce_line      = 1'b0;
      sclk_line    = 1'b0;
      sda_line     = 1'b0;
      drive_line   = 1'b1;
   endtask

   // Advance the predicted master by one bus tick and return the line levels
   function automatic rsp_payload_type bus_tick(input req_payload_type t);
      rsp_payload_type r;
      int              ofs;
      int              v;
      int              hi;
      logic [7:0]      bcd;
      slot_type        slot;
      logic            done;
      done = 1'b0;
      if (seq_phase == PH_IDLE) begin
         if (t.start_req) begin
            xfer_read = (t.op == OP_READ);
            if (t.op == OP_READ) begin
               tx_bits = {8'h00, t.reg_addr | 8'h01};
            end else begin
               v = int'(t.value);
               bcd = 8'(((v / 10) << 4) | (v % 10));
               tx_bits = {bcd, t.reg_addr & 8'hFE};
            end
            rx_bits   = '0;
            ce_line   = 1'b0;
            sclk_line = 1'b0;
            seq_phase = PH_CE_HIGH;
         end
      end else if (seq_phase == PH_CE_HIGH) begin
         ce_line   = 1'b1;
         seq_phase = PH_BITS;
      end else if (seq_phase < PH_SDA_LOW) begin
         ofs  = int'(seq_phase - PH_BITS);
         slot = slot_type'(2'(ofs % 3));
         case (slot)
            SLOT_DATA: begin
               if (xfer_read && ofs / 3 >= BYTE_BITS) begin
                  drive_line = 1'b0;
                  rx_bits    = {t.sda_in, rx_bits[7:1]};
               end else begin
                  drive_line = 1'b1;
                  sda_line   = tx_bits[0];
                  tx_bits    = tx_bits >> 1;
               end
            end
            SLOT_CLK_HIGH: sclk_line = 1'b1;
            default:       sclk_line = 1'b0;
         endcase
         seq_phase = seq_phase + 1'b1;
      end else if (seq_phase == PH_SDA_LOW) begin
         drive_line = 1'b1;
         sda_line   = 1'b0;
         seq_phase  = PH_END;
      end else if (seq_phase == PH_END) begin
         ce_line = 1'b0;
         done    = 1'b1;
         if (xfer_read) begin
            hi = int'(rx_bits[7:4]);
            last_decoded = 8'(hi * 10 + int'(rx_bits[3:0]));
         end
         seq_phase = PH_IDLE;
      end else begin
         seq_phase = PH_IDLE;
      end
      r.ce         = ce_line;
      r.sclk       = sclk_line;
      r.sda_out    = drive_line ? sda_line : 1'b0;
      r.sda_drive  = drive_line;
      r.busy_res   = (seq_phase != PH_IDLE);
      r.done_res   = done;
      r.read_value = last_decoded;
      return r;
   endfunction

   // Mostly no gap, some short, a few long; now and then a calm stretch
   function automatic int pick_idle(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 199);
      if (r == 0) begin
         calm = $urandom_range(40, 150);
         return 0;
      end
      if (r < 120) return 0;
      if (r < 180) return $urandom_range(1, 2);
      if (r < 196) return $urandom_range(3, 6);
      return $urandom_range(10, 30);
   endfunction

   task automatic report_fault(input string what, input int want, input int got);
      n_faults++;
      if (n_faults <= MAX_REPORTS)
         $display("mismatch after %0d results: %s expected %0h got %0h",
                  n_checked, what, want, got);
   endtask

   function automatic req_payload_type random_beat();
      req_payload_type b;
      b.start_req = 1'($urandom_range(0, 1));
      b.op        = 1'($urandom_range(0, 1));
      b.reg_addr  = 8'($urandom_range(0, 255));
      b.value     = 7'($urandom_range(0, 127));
      b.sda_in    = 1'($urandom_range(0, 1));
      return b;
   endfunction

   // One whole transfer; restart_pct sets how often start is raised while busy
   task automatic add_transfer(input logic rd, input logic [7:0] addr,
                               input logic [6:0] val, input logic [7:0] rd_byte,
                               input int restart_pct, input bit hold);
      tick_item_type it;
      int            k;
      for (k = 0; k < XFER_TICKS; k++) begin
         it.beat = random_beat();
         it.hold = 1'b0;
         it.beat.start_req = ($urandom_range(0, 99) < restart_pct);
         if (k == 0) begin
            it.beat.start_req = 1'b1;
            it.beat.op        = rd;
            it.beat.reg_addr  = addr;
            it.beat.value     = val;
            it.hold           = hold;
         end else if (k >= 2 && (k - 2) % 3 == 0 && (k - 2) / 3 >= BYTE_BITS) begin
            it.beat.sda_in = rd_byte[(k - 2) / 3 - BYTE_BITS];
         end
         pending_ticks.push_back(it);
      end
   endtask

   task automatic add_idle(input int n);
      tick_item_type it;
      int            k;
      for (k = 0; k < n; k++) begin
         it.beat = random_beat();
         it.beat.start_req = 1'b0;
         it.hold = 1'b0;
         pending_ticks.push_back(it);
      end
   endtask

   // Request driver
   always @(posedge clock) begin : tick_driver
      bit launch;
      if (reset) begin
         req_valid <= 1'b0;
         clear_bus_state();
      end else begin
         launch = !req_valid;
         if (req_valid && !req_stall) begin
            expected_lines.push_back(bus_tick(req_data));
            launch = 1'b1;
         end
         if (launch) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_ticks.size() > 0 &&
                         (!pending_ticks[0].hold || expected_lines.size() == 0)) begin
               req_valid <= 1'b1;
               req_data  <= pending_ticks[0].beat;
               void'(pending_ticks.pop_front());
               req_gap = pick_idle(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin : line_monitor
      rsp_payload_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_lines.size() == 0) begin
               report_fault("result beat with nothing expected", 0, int'(rsp_data));
            end else begin
               want = expected_lines.pop_front();
               if (rsp_data.ce !== want.ce)
                  report_fault("ce", want.ce, rsp_data.ce);
               if (rsp_data.sclk !== want.sclk)
                  report_fault("sclk", want.sclk, rsp_data.sclk);
               if (rsp_data.sda_out !== want.sda_out)
                  report_fault("sda_out", want.sda_out, rsp_data.sda_out);
               if (rsp_data.sda_drive !== want.sda_drive)
                  report_fault("sda_drive", want.sda_drive, rsp_data.sda_drive);
               if (rsp_data.busy_res !== want.busy_res)
                  report_fault("busy_res", want.busy_res, rsp_data.busy_res);
               if (rsp_data.done_res !== want.done_res)
                  report_fault("done_res", want.done_res, rsp_data.done_res);
               if (rsp_data.read_value !== want.read_value)
                  report_fault("read_value", want.read_value, rsp_data.read_value);
            end
            n_checked++;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            rsp_hold = pick_idle(rsp_calm);
         end
      end
   end

   initial begin : stimulus
      int         queued;
      int         n_total;
      logic       rd;
      logic [7:0] rd_byte;
      logic [6:0] val;

      // directed: address extremes, value extremes and above 99, bad BCD read
      add_transfer(OP_WRITE, 8'hFF, 7'd0, 8'h00, 0, 1'b0);
      add_idle(2);
      add_transfer(OP_WRITE, 8'h00, 7'd99, 8'h00, 0, 1'b0);
      add_transfer(OP_WRITE, 8'hAA, 7'd127, 8'h00, 0, 1'b0);
      add_transfer(OP_READ, 8'h00, 7'd0, 8'hFF, 100, 1'b1);   // start held while busy
      add_transfer(OP_READ, 8'hFF, 7'd127, 8'h59, 0, 1'b0);
      add_transfer(OP_WRITE, 8'h55, 7'd100, 8'h00, 0, 1'b0);

      // random: mostly whole transfers, some stray start and idle ticks
      queued = 0;
      while (pending_ticks.size() < TOTAL_TICKS) begin
         if ($urandom_range(0, 9) == 0)
            add_idle($urandom_range(1, 6));
         rd  = 1'($urandom_range(0, 1));
         val = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(100, 127))
                                           : 7'($urandom_range(0, 99));
         if ($urandom_range(0, 9) < 6)
            rd_byte = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
         else
            rd_byte = 8'($urandom_range(0, 255));
         add_transfer(rd, 8'($urandom_range(0, 255)), val, rd_byte,
                      $urandom_range(0, 30), (queued == 0) || ($urandom_range(0, 9) == 0));
         if ($urandom_range(0, 2) != 0)
            add_idle($urandom_range(0, 3));
         queued += XFER_TICKS;
      end
      n_total = pending_ticks.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (n_checked < n_total || pending_ticks.size() != 0 || req_valid ||
             expected_lines.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (n_faults == 0 && expected_lines.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule
